// File: design/pscp_pkg.sv
`timescale 1ns / 1ps
// Package: shared types and constants of the pedal sensor calibration and plausibility block
package pscp_pkg;

	localparam int unsigned CFG_W     = 12;
	localparam int unsigned PCT_W     = 7;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned NCH       = 4;
	localparam int unsigned CH_W      = 2;

	localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
	localparam logic [PCT_W-1:0] GAP_LIMIT = 7'd10;
	localparam logic [14:0]      LOW_RESET = 15'h7FFF;

	localparam logic [CFG_W-1:0] OPEN_RESET   = 12'd100;
	localparam logic [CFG_W-1:0] SHORT_RESET  = 12'd4000;
	localparam logic [CFG_W-1:0] THR_MIN_RST  = 12'd500;
	localparam logic [CFG_W-1:0] FB_MIN_RST   = 12'd200;
	localparam logic [CFG_W-1:0] LIGHT_RESET  = 12'd1000;
	localparam logic [PCT_W-1:0] DZ_RESET     = 7'd5;

	typedef enum logic [KIND_W-1:0] {
		KIND_CAL = 2'd0,
		KIND_RUN = 2'd1,
		KIND_DZ  = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OPEN_LVL  = 3'd0,
		CFG_SHORT_LVL = 3'd1,
		CFG_TA_MIN    = 3'd2,
		CFG_TB_MIN    = 3'd3,
		CFG_FB_MIN    = 3'd4,
		CFG_LIGHT_LVL = 3'd5,
		CFG_THR_DZ    = 3'd6,
		CFG_BRK_DZ    = 3'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEARN,
		ST_SETUP,
		ST_DIV,
		ST_STORE,
		ST_FINISH
	} state_t;

endpackage

// File: design/pedal_sensor_calibrate_plausibility.sv
`timescale 1ns / 1ps
// Top level: pedal sensor calibration, scaling and plausibility check
//
// Input channel s_*: one item carries four pedal ADC readings (throttle A,
// throttle B, front brake, rear brake) in s_tdata and the item kind in s_tuser
// (calibration sample, run sample, deadzone event; the unused code is dropped).
// Output channel m_*: one item per calibration or run sample, none otherwise.
// Configuration channel cfg_*: always ready, one register write per cycle.
// One item is in work at a time; s_tready is high only while idle.
// Each channel goes through one shared restoring divider, one quotient bit per
// cycle. Per sensor, a calibration sample takes the steps learn, set-up, 7
// quotient bits and store; a run sample takes the same steps with no learn
// step; an uncalibrated or saturated sensor skips the quotient bits. After the
// last sensor the result is registered and m_tvalid rises; the next item is taken once the block is idle again.
// Deadzone event: set-up, quotient bits and store per sensor, no output item.
// The output register holds a finished item while m_tready is low; the next
// item is still accepted, and its result waits in the last step until the
// register frees.
// Reset: learned minima go to 7FFF hex, maxima to zero, spans to one, and the
// registers to their defaults; no item is in work and m_tvalid is low.
module pedal_sensor_calibrate_plausibility
	import pscp_pkg::*;
#(
	parameter int unsigned ADC_BITS = 12
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// throttle_a_raw, throttle_b_raw, brake_front_raw, brake_rear_raw, zero fill
	input  logic [((4*ADC_BITS+7)/8)*8-1:0]           s_tdata,
	// kind
	input  logic [KIND_W-1:0]                         s_tuser,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// throttle_a_percent, throttle_b_percent, brake_percent, brake_raw_out,
	// throttle_fault, throttles_calibrated, braking_flag, zero fill
	output logic [((3*PCT_W+ADC_BITS+3+7)/8)*8-1:0]   m_tdata,
	// rear_brake_selected
	output logic [0:0]                                m_tuser,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]                      cfg_index,
	input  logic [CFG_W-1:0]                          cfg_data
);

	localparam int unsigned AB    = ADC_BITS;
	localparam int unsigned LW    = (AB > 15) ? AB : 15;
	localparam int unsigned NW    = AB + PCT_W;
	localparam int unsigned QW    = AB + 1;
	localparam int unsigned CNT_W = $clog2(QW);
	localparam int unsigned XW    = (AB > CFG_W) ? AB : CFG_W;
	localparam int unsigned OUT_W = ((3*PCT_W+AB+3+7)/8)*8;

	logic [CFG_W-1:0] open_lvl_q, short_lvl_q, ta_min_q, tb_min_q, fb_min_q, light_lvl_q;
	logic [PCT_W-1:0] thr_dz_q, brk_dz_q;

	state_t state_q, state_d;
	logic [KIND_W-1:0] kind_q;
	logic [CH_W-1:0]   ch_q;
	logic [AB-1:0]     raw_q  [NCH];
	logic [LW-1:0]     low_q  [NCH];
	logic [AB-1:0]     high_q [NCH];
	logic [AB-1:0]     span_q [NCH];
	logic [PCT_W-1:0]  pct_q  [NCH];

	logic [AB-1:0]     div_q, rem_q;
	logic [QW-1:0]     num_q, quo_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;
	logic              out_user_q;

	// per-channel view
	logic [AB-1:0] raw_c, hi_c, sp_c;
	logic [LW-1:0] lo_c;
	logic          up_hi, dn_lo;
	logic [AB-1:0] new_hi, new_sp;
	logic [LW-1:0] new_lo;
	logic          uncal, pct_sat;
	logic [AB-1:0] clip_hi, clip, delta;
	logic [NW-1:0] pct_num, dz_num;
	logic [PCT_W-1:0] dz_pct;

	// divider step
	logic [AB:0]   step_t, step_diff;
	logic          step_ge;

	// store step
	logic          dz_skip;
	logic [LW:0]   dz_low;
	logic [PCT_W-1:0] pct_res;

	// result
	logic          rear, fault, cal, braking;
	logic [PCT_W-1:0] bsel_pct, gap;
	logic [AB-1:0] bsel_raw;

	// control
	logic dz_mode, last_ch, out_free, in_take, do_learn, do_setup, do_div, do_store, out_load;
	logic setup_div;

	assign raw_c = raw_q[ch_q];
	assign lo_c  = low_q[ch_q];
	assign hi_c  = high_q[ch_q];
	assign sp_c  = span_q[ch_q];

	always_comb begin
		up_hi  = raw_c > hi_c;
		dn_lo  = !up_hi && (LW'(raw_c) < lo_c);
		new_hi = up_hi ? raw_c : hi_c;
		new_lo = dn_lo ? LW'(raw_c) : lo_c;
		new_sp = (LW'(new_hi) > new_lo) ? AB'(LW'(new_hi) - new_lo) : sp_c;
	end

	always_comb begin
		uncal   = (LW'(hi_c) <= lo_c) || (sp_c == '0);
		clip_hi = (raw_c > hi_c) ? hi_c : raw_c;
		clip    = (LW'(clip_hi) < lo_c) ? lo_c[AB-1:0] : clip_hi;
		delta   = clip - lo_c[AB-1:0];
		pct_num = NW'(delta) * NW'(PCT_FULL);
		pct_sat = pct_num >= {sp_c, {PCT_W{1'b0}}};
		dz_pct  = ch_q[1] ? brk_dz_q : thr_dz_q;
		dz_num  = NW'(sp_c) * NW'(dz_pct);
	end

	always_comb begin
		step_t    = {rem_q, num_q[QW-1]};
		step_diff = step_t - {1'b0, div_q};
		step_ge   = step_t >= {1'b0, div_q};
	end

	always_comb begin
		dz_skip = quo_q >= QW'(sp_c);
		dz_low  = (LW+1)'(lo_c) + (LW+1)'(quo_q);
		pct_res = (quo_q > QW'(PCT_FULL)) ? PCT_FULL : quo_q[PCT_W-1:0];
	end

	always_comb begin
		rear     = (XW'(span_q[2]) < XW'(fb_min_q)) || (pct_q[3] > pct_q[2]);
		bsel_pct = rear ? pct_q[3] : pct_q[2];
		bsel_raw = rear ? raw_q[3] : raw_q[2];
		gap      = (pct_q[0] > pct_q[1]) ? pct_q[0] - pct_q[1] : pct_q[1] - pct_q[0];
		fault    = (gap > GAP_LIMIT)
			|| (XW'(raw_q[0]) < XW'(open_lvl_q)) || (XW'(raw_q[0]) > XW'(short_lvl_q))
			|| (XW'(raw_q[1]) < XW'(open_lvl_q)) || (XW'(raw_q[1]) > XW'(short_lvl_q));
		cal      = (XW'(span_q[0]) > XW'(ta_min_q)) && (XW'(span_q[1]) > XW'(tb_min_q));
		braking  = XW'(bsel_raw) > XW'(light_lvl_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					priority if (s_tuser == KIND_CAL) begin
						state_d = ST_LEARN;
					end else if ((s_tuser == KIND_RUN) || (s_tuser == KIND_DZ)) begin
						state_d = ST_SETUP;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_LEARN: begin
				state_d = ST_SETUP;
			end
			ST_SETUP: begin
				state_d = setup_div ? ST_DIV : ST_STORE;
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				priority if (last_ch) begin
					state_d = dz_mode ? ST_IDLE : ST_FINISH;
				end else if (kind_q == KIND_CAL) begin
					state_d = ST_LEARN;
				end else begin
					state_d = ST_SETUP;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		dz_mode   = kind_q == KIND_DZ;
		last_ch   = ch_q == CH_W'(NCH-1);
		out_free  = !out_valid_q || m_tready;
		setup_div = dz_mode || (!uncal && !pct_sat);
		s_tready  = state_q == ST_IDLE;
		in_take   = s_tvalid && (state_q == ST_IDLE);
		do_learn  = state_q == ST_LEARN;
		do_setup  = state_q == ST_SETUP;
		do_div    = state_q == ST_DIV;
		do_store  = state_q == ST_STORE;
		out_load  = (state_q == ST_FINISH) && out_free;
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign m_tuser   = out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_lvl_q  <= OPEN_RESET;
			short_lvl_q <= SHORT_RESET;
			ta_min_q    <= THR_MIN_RST;
			tb_min_q    <= THR_MIN_RST;
			fb_min_q    <= FB_MIN_RST;
			light_lvl_q <= LIGHT_RESET;
			thr_dz_q    <= DZ_RESET;
			brk_dz_q    <= DZ_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_OPEN_LVL:  open_lvl_q  <= cfg_data;
				CFG_SHORT_LVL: short_lvl_q <= cfg_data;
				CFG_TA_MIN:    ta_min_q    <= cfg_data;
				CFG_TB_MIN:    tb_min_q    <= cfg_data;
				CFG_FB_MIN:    fb_min_q    <= cfg_data;
				CFG_LIGHT_LVL: light_lvl_q <= cfg_data;
				CFG_THR_DZ:    thr_dz_q    <= cfg_data[PCT_W-1:0];
				CFG_BRK_DZ:    brk_dz_q    <= cfg_data[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NCH; i++) begin
				low_q[i]  <= LW'(LOW_RESET);
				high_q[i] <= '0;
				span_q[i] <= AB'(1);
			end
		end else begin
			state_q <= state_d;
			if (in_take) begin
				ch_q <= '0;
			end else if (do_store) begin
				ch_q <= ch_q + CH_W'(1);
			end
			if (do_learn) begin
				low_q[ch_q]  <= new_lo;
				high_q[ch_q] <= new_hi;
				span_q[ch_q] <= new_sp;
			end
			if (do_store && dz_mode && !dz_skip) begin
				low_q[ch_q]  <= (dz_low > (LW+1)'(LOW_RESET)) ? LW'(LOW_RESET) : dz_low[LW-1:0];
				span_q[ch_q] <= sp_c - quo_q[AB-1:0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_q <= s_tuser;
			for (int i = 0; i < NCH; i++) begin
				raw_q[i] <= s_tdata[i*AB +: AB];
			end
		end
		if (do_setup) begin
			priority if (dz_mode) begin
				quo_q <= '0;
				div_q <= AB'(PCT_FULL);
				rem_q <= AB'(dz_num[NW-1:QW]);
				num_q <= dz_num[QW-1:0];
				cnt_q <= CNT_W'(QW-1);
			end else if (uncal) begin
				quo_q <= '0;
			end else if (pct_sat) begin
				quo_q <= QW'(PCT_FULL);
			end else begin
				quo_q <= '0;
				div_q <= sp_c;
				rem_q <= pct_num[NW-1:PCT_W];
				num_q <= {pct_num[PCT_W-1:0], {(QW-PCT_W){1'b0}}};
				cnt_q <= CNT_W'(PCT_W-1);
			end
		end
		if (do_div) begin
			rem_q <= step_ge ? step_diff[AB-1:0] : step_t[AB-1:0];
			num_q <= {num_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], step_ge};
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (do_store && !dz_mode) begin
			pct_q[ch_q] <= pct_res;
		end
		if (out_load) begin
			out_data_q <= OUT_W'({braking, cal, fault, bsel_raw, bsel_pct, pct_q[1], pct_q[0]});
			out_user_q <= rear;
		end
	end

endmodule

// File: design/pscp_checker.sv
`timescale 1ns / 1ps
// Checker: port-level properties of the pedal sensor block, bound to the top level
module pscp_checker
	import pscp_pkg::*;
#(
	parameter int unsigned ADC_BITS = 12
) (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    s_tvalid,
	input logic                                    s_tready,
	input logic [KIND_W-1:0]                       s_tuser,
	input logic                                    m_tvalid,
	input logic                                    m_tready,
	input logic [((3*PCT_W+ADC_BITS+3+7)/8)*8-1:0] m_tdata,
	input logic [0:0]                              m_tuser
);

	// hold a stalled item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready
			&& ((s_tuser == KIND_CAL) || (s_tuser == KIND_RUN) || (s_tuser == KIND_DZ))
		|=> !s_tready)
		else $error("second item taken while one is in work");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[PCT_W-1:0] <= PCT_FULL)
			&& (m_tdata[2*PCT_W-1:PCT_W] <= PCT_FULL)
			&& (m_tdata[3*PCT_W-1:2*PCT_W] <= PCT_FULL))
		else $error("percentage above full scale");

endmodule

bind pedal_sensor_calibrate_plausibility pscp_checker #(
	.ADC_BITS(ADC_BITS)
) u_pscp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: dv/tb_pedal_sensor_calibrate_plausibility.sv
`timescale 1ns / 1ps
// Testbench: pedal sensor calibration and plausibility block against a cycle-free predictor
module tb_pedal_sensor_calibrate_plausibility;
	import pscp_pkg::*;

	localparam int unsigned ADC_W       = 12;
	localparam int unsigned ADC_MAX     = 4095;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned SETTLE      = 80;
	localparam int unsigned PHASES      = 8;
	localparam int unsigned PHASE_ITEMS = 200;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	localparam int CH_TA = 0;
	localparam int CH_TB = 1;
	localparam int CH_FB = 2;
	localparam int CH_RB = 3;

	typedef logic [NCH-1:0][ADC_W-1:0] raw_set_t;
	typedef logic [7:0][CFG_W-1:0] reg_bank_t;

	typedef struct packed {
		logic [3:0]       fill;
		logic             braking;
		logic             cal;
		logic             fault;
		logic [ADC_W-1:0] brk_raw;
		logic [PCT_W-1:0] brk_pct;
		logic [PCT_W-1:0] tb_pct;
		logic [PCT_W-1:0] ta_pct;
	} pedal_word_t;

	typedef struct packed {
		pedal_word_t word;
		logic        rear;
	} pedal_expect_t;

	localparam reg_bank_t DEFAULT_BANK = {
		{5'd0, DZ_RESET}, {5'd0, DZ_RESET}, LIGHT_RESET, FB_MIN_RST,
		THR_MIN_RST, THR_MIN_RST, SHORT_RESET, OPEN_RESET
	};

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [47:0]          s_tdata;   // throttle_a_raw, throttle_b_raw, brake_front_raw, brake_rear_raw
	logic [KIND_W-1:0]    s_tuser;   // kind
	logic                 m_tvalid;
	logic                 m_tready;
	logic [39:0]          m_tdata;   // throttle_a_percent, throttle_b_percent, brake_percent,
	                                 // brake_raw_out, throttle_fault, throttles_calibrated,
	                                 // braking_flag, zero fill
	logic [0:0]           m_tuser;   // rear_brake_selected
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	reg_bank_t        reg_shadow;
	logic [14:0]      min_seen  [NCH];
	logic [ADC_W-1:0] max_seen  [NCH];
	logic [ADC_W-1:0] span_seen [NCH];

	pedal_expect_t pending_pedal_results[$];
	int unsigned   mismatch_count;
	bit            idling;
	bit            hold_output;

	pedal_sensor_calibrate_plausibility u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [ADC_W-1:0] to_adc(int v);
		if (v < 0)
			return '0;
		if (v > int'(ADC_MAX))
			return '1;
		return ADC_W'(v);
	endfunction

	function automatic raw_set_t raws(int unsigned ta, int unsigned tb, int unsigned fb,
			int unsigned rb);
		raw_set_t r;
		r[CH_TA] = ADC_W'(ta);
		r[CH_TB] = ADC_W'(tb);
		r[CH_FB] = ADC_W'(fb);
		r[CH_RB] = ADC_W'(rb);
		return r;
	endfunction

	function automatic raw_set_t random_raws();
		raw_set_t r;
		for (int ch = 0; ch < NCH; ch++) begin
			case ($urandom_range(0, 7))
				0: r[ch] = '0;
				1: r[ch] = '1;
				2: r[ch] = to_adc(int'(ch < CH_FB ? reg_shadow[CFG_OPEN_LVL] :
					reg_shadow[CFG_LIGHT_LVL]) + int'($urandom_range(0, 2)) - 1);
				3: r[ch] = to_adc(int'(ch < CH_FB ? 15'(reg_shadow[CFG_SHORT_LVL]) :
					min_seen[ch]) + int'($urandom_range(0, 2)) - 1);
				default: r[ch] = ADC_W'($urandom_range(0, ADC_MAX));
			endcase
		end
		// keep the throttles close half the time so the gap check sits near its limit
		if ($urandom_range(0, 1))
			r[CH_TB] = to_adc(int'(r[CH_TA]) + int'($urandom_range(0, 30)) - 15);
		return r;
	endfunction

	function automatic logic [CFG_W-1:0] pick_setting(int unsigned lo, int unsigned hi,
			int unsigned top);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return CFG_W'(top);
			default: return CFG_W'($urandom_range(lo, hi));
		endcase
	endfunction

	task automatic predict_pedal_result(logic [KIND_W-1:0] kind, raw_set_t raw);
		int unsigned   lo, hi, c, sp, pc, dz, gap;
		int unsigned   pct [NCH];
		pedal_expect_t e;
		if (kind == KIND_UNUSED)
			return;
		for (int ch = 0; ch < NCH; ch++) begin
			if (kind == KIND_DZ) begin
				sp = span_seen[ch];
				pc = ch < CH_FB ? reg_shadow[CFG_THR_DZ] : reg_shadow[CFG_BRK_DZ];
				dz = sp * pc / PCT_FULL;
				if (dz < sp) begin
					lo = min_seen[ch];
					lo = lo + dz;
					min_seen[ch] = 15'(lo > LOW_RESET ? LOW_RESET : lo);
					span_seen[ch] = ADC_W'(sp - dz);
				end
			end else if (kind == KIND_CAL) begin
				if (raw[ch] > max_seen[ch])
					max_seen[ch] = raw[ch];
				else if (raw[ch] < min_seen[ch])
					min_seen[ch] = raw[ch];
				if (max_seen[ch] > min_seen[ch])
					span_seen[ch] = ADC_W'(max_seen[ch] - min_seen[ch]);
			end
		end
		if (kind == KIND_DZ)
			return;
		for (int ch = 0; ch < NCH; ch++) begin
			lo = min_seen[ch];
			hi = max_seen[ch];
			// no learned range yet: report zero
			if (hi <= lo || span_seen[ch] == 0) begin
				pct[ch] = 0;
			end else begin
				c = raw[ch];
				if (c > hi)
					c = hi;
				if (c < lo)
					c = lo;
				pct[ch] = 100 * (c - lo) / span_seen[ch];
				if (pct[ch] > PCT_FULL)
					pct[ch] = PCT_FULL;
			end
		end
		e = '0;
		e.rear = (span_seen[CH_FB] < reg_shadow[CFG_FB_MIN]) || (pct[CH_RB] > pct[CH_FB]);
		e.word.ta_pct  = PCT_W'(pct[CH_TA]);
		e.word.tb_pct  = PCT_W'(pct[CH_TB]);
		e.word.brk_pct = PCT_W'(e.rear ? pct[CH_RB] : pct[CH_FB]);
		e.word.brk_raw = e.rear ? raw[CH_RB] : raw[CH_FB];
		gap = pct[CH_TA] > pct[CH_TB] ? pct[CH_TA] - pct[CH_TB] : pct[CH_TB] - pct[CH_TA];
		e.word.fault = (gap > GAP_LIMIT)
			|| (raw[CH_TA] < reg_shadow[CFG_OPEN_LVL]) || (raw[CH_TA] > reg_shadow[CFG_SHORT_LVL])
			|| (raw[CH_TB] < reg_shadow[CFG_OPEN_LVL]) || (raw[CH_TB] > reg_shadow[CFG_SHORT_LVL]);
		e.word.cal = (span_seen[CH_TA] > reg_shadow[CFG_TA_MIN])
			&& (span_seen[CH_TB] > reg_shadow[CFG_TB_MIN]);
		e.word.braking = e.word.brk_raw > reg_shadow[CFG_LIGHT_LVL];
		pending_pedal_results.push_back(e);
	endtask

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		mismatch_count++;
	endtask

	task automatic compare_field(string what, int unsigned got, int unsigned want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	always @(posedge clk) begin : result_check
		pedal_expect_t want;
		pedal_word_t   got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_pedal_results.size() == 0) begin
				report_mismatch("result with nothing pending", got.brk_raw, 0);
			end else begin
				want = pending_pedal_results.pop_front();
				compare_field("throttle_a_percent", got.ta_pct, want.word.ta_pct);
				compare_field("throttle_b_percent", got.tb_pct, want.word.tb_pct);
				compare_field("brake_percent", got.brk_pct, want.word.brk_pct);
				compare_field("brake_raw_out", got.brk_raw, want.word.brk_raw);
				compare_field("rear_brake_selected", m_tuser[0], want.rear);
				compare_field("throttle_fault", got.fault, want.word.fault);
				compare_field("throttles_calibrated", got.cal, want.word.cal);
				compare_field("braking_flag", got.braking, want.word.braking);
			end
		end
	end

	// output side: random stalls, plus one long hold on request
	initial begin : output_sink
		int unsigned stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_output) begin
				stall_left = 400;
				hold_output = 1'b0;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	task automatic send_sample(logic [KIND_W-1:0] kind, raw_set_t raw);
		if (idling && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= raw;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_pedal_result(kind, raw);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_pedal_results.size() != 0)
			@(posedge clk);
		// a deadzone or dropped item may still be in work
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic program_regs(reg_bank_t bank);
		cfg_idx_t idx;
		wait_idle();
		for (int i = 0; i < 8; i++) begin
			idx = cfg_idx_t'(i);
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= bank[idx];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			if (idx == CFG_THR_DZ || idx == CFG_BRK_DZ)
				reg_shadow[idx] = {5'd0, bank[idx][PCT_W-1:0]};
			else
				reg_shadow[idx] = bank[idx];
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_state();
		send_sample(KIND_RUN, raws(0, ADC_MAX, 2048, 100));
		send_sample(KIND_UNUSED, random_raws());
		send_sample(KIND_DZ, random_raws());
		send_sample(KIND_CAL, raws(2048, 2048, 2048, 2048));
	endtask

	task automatic test_learn_range();
		send_sample(KIND_CAL, raws(0, 0, 0, 0));
		send_sample(KIND_CAL, raws(ADC_MAX, ADC_MAX, ADC_MAX, ADC_MAX));
		send_sample(KIND_CAL, raws(ADC_MAX, 0, ADC_MAX, 0));
		send_sample(KIND_RUN, raws(0, 0, 0, 0));
		send_sample(KIND_RUN, raws(ADC_MAX, ADC_MAX, ADC_MAX, ADC_MAX));
		// wiring levels exactly on the limits
		send_sample(KIND_RUN, raws(100, 100, 1000, 1001));
		send_sample(KIND_RUN, raws(4000, 4000, 1001, 2000));
		send_sample(KIND_RUN, raws(99, 4001, 0, 0));
		// throttle gap of exactly ten, then eleven
		send_sample(KIND_RUN, raws(2048, 2458, 0, 0));
		send_sample(KIND_RUN, raws(2048, 2500, 0, 0));
	endtask

	task automatic test_deadzone();
		reg_bank_t bank;
		send_sample(KIND_DZ, random_raws());
		send_sample(KIND_RUN, raws(100, ADC_MAX, 204, 300));
		// full-span deadzone leaves throttles alone; zero leaves brakes alone
		bank = DEFAULT_BANK;
		bank[CFG_THR_DZ] = CFG_W'(100);
		bank[CFG_BRK_DZ] = '0;
		program_regs(bank);
		send_sample(KIND_DZ, random_raws());
		send_sample(KIND_RUN, raws(2000, 2100, 3000, 1000));
		// near-full throttle shrink; brake percent above the valid range
		bank[CFG_THR_DZ] = CFG_W'(99);
		bank[CFG_BRK_DZ] = CFG_W'(127);
		program_regs(bank);
		send_sample(KIND_DZ, random_raws());
		send_sample(KIND_RUN, raws(4060, ADC_MAX, 0, ADC_MAX));
	endtask

	task automatic test_register_extremes();
		reg_bank_t bank;
		program_regs('0);
		send_sample(KIND_RUN, raws(0, 0, 0, 0));
		bank = {8{12'(ADC_MAX)}};
		bank[CFG_THR_DZ] = CFG_W'(PCT_FULL);
		bank[CFG_BRK_DZ] = CFG_W'(PCT_FULL);
		program_regs(bank);
		send_sample(KIND_RUN, raws(ADC_MAX, ADC_MAX, ADC_MAX, ADC_MAX));
		send_sample(KIND_DZ, random_raws());
	endtask

	task automatic test_output_stall();
		program_regs(DEFAULT_BANK);
		@(posedge clk);
		hold_output = 1'b1;
		@(negedge clk);
		for (int i = 0; i < 6; i++)
			send_sample(KIND_RUN, random_raws());
		wait_idle();
	endtask

	task automatic test_random_traffic();
		reg_bank_t        bank;
		int unsigned      roll;
		logic [KIND_W-1:0] kind;
		for (int phase = 0; phase < PHASES; phase++) begin
			bank[CFG_OPEN_LVL]  = pick_setting(0, 400, ADC_MAX);
			bank[CFG_SHORT_LVL] = pick_setting(3600, ADC_MAX, ADC_MAX);
			bank[CFG_TA_MIN]    = pick_setting(0, ADC_MAX, ADC_MAX);
			bank[CFG_TB_MIN]    = pick_setting(0, ADC_MAX, ADC_MAX);
			bank[CFG_FB_MIN]    = pick_setting(0, ADC_MAX, ADC_MAX);
			bank[CFG_LIGHT_LVL] = pick_setting(0, ADC_MAX, ADC_MAX);
			bank[CFG_THR_DZ]    = pick_setting(0, 60, PCT_FULL);
			bank[CFG_BRK_DZ]    = pick_setting(0, 60, PCT_FULL);
			program_regs(bank);
			// drop idling for the final stretch
			if (phase == PHASES - 1)
				idling = 1'b0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 10)
					kind = KIND_CAL;
				else if (roll < 18)
					kind = KIND_DZ;
				else if (roll < 21)
					kind = KIND_UNUSED;
				else
					kind = KIND_RUN;
				send_sample(kind, random_raws());
			end
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = KIND_RUN;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_OPEN_LVL;
		cfg_data    = '0;
		idling      = 1'b1;
		hold_output = 1'b0;
		mismatch_count = 0;
		reg_shadow  = DEFAULT_BANK;
		for (int ch = 0; ch < NCH; ch++) begin
			min_seen[ch]  = LOW_RESET;
			max_seen[ch]  = '0;
			span_seen[ch] = 1;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_state();
		test_learn_range();
		test_deadzone();
		test_register_extremes();
		test_output_stall();
		test_random_traffic();

		wait_idle();
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
